@@ rtl/keyed_event_counter_table_core_macros.svh @@
// Assertion macros shared by the counter table RTL.
`ifndef KEYED_EVENT_COUNTER_TABLE_CORE_MACROS_SVH
`define KEYED_EVENT_COUNTER_TABLE_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define KECT_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define KECT_ASSERT_SAME(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define KECT_ASSERT_NEXT(label, trig, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error(msg);

`endif

@@ rtl/kect_pkg.sv @@
// Shared constants, types and functions of the keyed event counter table.
package kect_pkg;

	// Table geometry.
	localparam int ENTRIES = 16;
	localparam int CNT_W = 16;
	localparam int ID_W = 22;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// Field widths of the channels.
	localparam int REQ_W = 2;
	localparam int STAT_W = 2;
	localparam int OUT_IDX_W = 4;
	localparam int OUT_CNT_W = 16;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_T1 = 2'd0;
	localparam logic [REQ_W-1:0] REQ_T2 = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DUMP = 2'd2;

	// Status codes; a dump beat carries STAT_DUMP.
	localparam logic [STAT_W-1:0] STAT_NEW = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OLD = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;
	localparam logic [STAT_W-1:0] STAT_DUMP = 2'd0;

	// Result kinds.
	localparam logic KIND_ACK = 1'b0;
	localparam logic KIND_DUMP = 1'b1;

	// Contents of one table cell.
	typedef struct packed {
		logic             occ;
		logic [ID_W-1:0]  id;
		logic [CNT_W-1:0] c1;
		logic [CNT_W-1:0] c2;
	} kect_entry_t;

	// Command broadcast to every cell.
	typedef struct packed {
		logic [ID_W-1:0] key;
		logic            t1;
		logic            upd_en;
		logic            alloc_en;
		logic            shift_en;
	} kect_ctl_t;

	// One result beat.
	typedef struct packed {
		logic                 kind;
		logic [STAT_W-1:0]    status;
		logic [OUT_IDX_W-1:0] index;
		logic                 valid;
		logic [ID_W-1:0]      id;
		logic [OUT_CNT_W-1:0] c1;
		logic [OUT_CNT_W-1:0] c2;
		logic                 last;
	} kect_rsp_t;

	// Counter increment that stops at the top value.
	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (&v) ? v : v + CNT_W'(1);
	endfunction

endpackage

@@ rtl/kect_req_if.sv @@
// Request channel: event or dump beats into the table.
interface kect_req_if;
	logic                       valid;
	logic                       ready;
	logic [kect_pkg::REQ_W-1:0] req_type;
	logic [kect_pkg::ID_W-1:0]  sender_id;

	modport source (output valid, output req_type, output sender_id, input ready);
	modport sink (input valid, input req_type, input sender_id, output ready);
endinterface

@@ rtl/kect_rsp_if.sv @@
// Result channel: acknowledges and dump beats out of the table.
interface kect_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           result_kind;
	logic [kect_pkg::STAT_W-1:0]    status;
	logic [kect_pkg::OUT_IDX_W-1:0] entry_index;
	logic                           entry_valid;
	logic [kect_pkg::ID_W-1:0]      source_id;
	logic [kect_pkg::OUT_CNT_W-1:0] type1_count;
	logic [kect_pkg::OUT_CNT_W-1:0] type2_count;
	logic                           last;

	modport source (output valid, output result_kind, output status, output entry_index,
		output entry_valid, output source_id, output type1_count, output type2_count,
		output last, input ready);
	modport sink (input valid, input result_kind, input status, input entry_index,
		input entry_valid, input source_id, input type1_count, input type2_count,
		input last, output ready);
endinterface

@@ rtl/kect_cell.sv @@
// One table cell: holds a source id and its two counters, shifts toward cell 0 on dump.
module kect_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  kect_pkg::kect_ctl_t   ctl,
	input  logic                  prev_occ,
	input  kect_pkg::kect_entry_t nb_in,
	output kect_pkg::kect_entry_t cur,
	output logic                  hit
);
	import kect_pkg::*;

	logic             occ_q;
	logic [ID_W-1:0]  id_q;
	logic [CNT_W-1:0] c1_q;
	logic [CNT_W-1:0] c2_q;
	logic             alloc_here;

	// Key compare and first-free detection along the chain.
	assign hit = occ_q && (id_q == ctl.key);
	assign alloc_here = ctl.alloc_en && !occ_q && prev_occ;

	assign cur.occ = occ_q;
	assign cur.id = id_q;
	assign cur.c1 = c1_q;
	assign cur.c2 = c2_q;

	// Occupancy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= 1'b0;
		end else if (ctl.shift_en) begin
			occ_q <= nb_in.occ;
		end else if (alloc_here) begin
			occ_q <= 1'b1;
		end
	end

	// Id and counters: shift, fresh allocation or counting.
	always_ff @(posedge clk) begin
		if (ctl.shift_en) begin
			id_q <= nb_in.id;
			c1_q <= nb_in.c1;
			c2_q <= nb_in.c2;
		end else if (alloc_here) begin
			id_q <= ctl.key;
			c1_q <= {{(CNT_W-1){1'b0}}, ctl.t1};
			c2_q <= {{(CNT_W-1){1'b0}}, !ctl.t1};
		end else if (ctl.upd_en && hit) begin
			if (ctl.t1) begin
				c1_q <= sat_inc(c1_q);
			end else begin
				c2_q <= sat_inc(c2_q);
			end
		end
	end

endmodule

@@ rtl/keyed_event_counter_table_core.sv @@
// Per-source event counter table: a row of cells with one result register.
//
// Requests arrive on req: type-1 or type-2 events keyed by sender_id, or a
// dump request. Results leave on rsp through one output register, so a new
// request is taken while a finished result still waits to be taken.
// An event is accepted, then in the lookup state every cell compares the
// key in parallel and the hit cell counts, or the first free cell in fill
// order is claimed. Its single acknowledge appears on rsp the cycle after
// that. Requests with type 3 are taken and dropped.
// A dump shifts the row one cell toward cell 0 per beat and emits cell 0,
// so it gives one beat per stored entry (one beat when the table is empty);
// the shifting also empties the table.
// Reset clears every cell's occupancy flag; the table is empty at once with
// no clearing pass. When rsp is stalled the result register holds, and the
// row does not advance until the register can take the next beat.
`include "keyed_event_counter_table_core_macros.svh"

module keyed_event_counter_table_core (
	input logic        clk,
	input logic        arst_n,
	kect_req_if.sink   req,
	kect_rsp_if.source rsp
);
	import kect_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOOK = 2'd1;
	localparam logic [1:0] ST_DUMP = 2'd2;

	logic [1:0]       state_q;
	logic [ID_W-1:0]  key_q;
	logic             t1_q;
	logic [IDX_W-1:0] dump_cnt_q;
	logic             out_valid_q;
	kect_rsp_t        rsp_q;

	kect_ctl_t        ctl;
	kect_entry_t      cur [ENTRIES];
	kect_entry_t      nb [ENTRIES];
	logic [ENTRIES-1:0] hit_vec;
	logic [ENTRIES-1:0] occ_vec;
	logic [ENTRIES-1:0] occ_inc;
	logic             out_free;
	logic             in_fire;
	logic             found;
	logic             full;
	logic [IDX_W-1:0] hit_idx;
	logic [IDX_W-1:0] free_idx;
	logic [CNT_W-1:0] sel_c1;
	logic [CNT_W-1:0] sel_c2;
	kect_rsp_t        look_rsp;
	kect_rsp_t        dump_rsp;

	// The row of cells; each one takes its upper neighbor's contents on a shift.
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		if (i == ENTRIES - 1) begin : g_tail
			assign nb[i] = '0;
		end else begin : g_link
			assign nb[i] = cur[i+1];
		end

		kect_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.prev_occ ((i == 0) ? 1'b1 : cur[(i == 0) ? 0 : i-1].occ),
			.nb_in    (nb[i]),
			.cur      (cur[i]),
			.hit      (hit_vec[i])
		);

		assign occ_vec[i] = cur[i].occ;
	end

	assign occ_inc = occ_vec + ENTRIES'(1);

	// Handshake terms.
	assign out_free = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign in_fire = req.valid && req.ready;

	// Commands to the row.
	assign ctl.key = key_q;
	assign ctl.t1 = t1_q;
	assign ctl.upd_en = (state_q == ST_LOOK) && out_free;
	assign ctl.alloc_en = (state_q == ST_LOOK) && out_free && !found;
	assign ctl.shift_en = (state_q == ST_DUMP) && out_free && cur[0].occ;

	// Hit selection and first free slot across the row.
	always_comb begin
		hit_idx = '0;
		free_idx = '0;
		sel_c1 = '0;
		sel_c2 = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (hit_vec[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
				sel_c1 = sel_c1 | cur[i].c1;
				sel_c2 = sel_c2 | cur[i].c2;
			end
			if (!occ_vec[i] && ((i == 0) || occ_vec[(i == 0) ? 0 : i-1])) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign found = |hit_vec;
	assign full = occ_vec[ENTRIES-1];

	// Acknowledge of an event.
	always_comb begin
		look_rsp = '0;
		look_rsp.kind = KIND_ACK;
		look_rsp.last = 1'b1;
		if (found) begin
			look_rsp.status = STAT_OLD;
			look_rsp.index = OUT_IDX_W'(hit_idx);
			look_rsp.valid = 1'b1;
			look_rsp.id = key_q;
			look_rsp.c1 = OUT_CNT_W'(t1_q ? sat_inc(sel_c1) : sel_c1);
			look_rsp.c2 = OUT_CNT_W'(t1_q ? sel_c2 : sat_inc(sel_c2));
		end else if (!full) begin
			look_rsp.status = STAT_NEW;
			look_rsp.index = OUT_IDX_W'(free_idx);
			look_rsp.valid = 1'b1;
			look_rsp.id = key_q;
			look_rsp.c1 = OUT_CNT_W'(t1_q);
			look_rsp.c2 = OUT_CNT_W'(!t1_q);
		end else begin
			look_rsp.status = STAT_FULL;
		end
	end

	// Dump beat taken from cell 0; an empty table gives one empty beat.
	always_comb begin
		dump_rsp = '0;
		dump_rsp.kind = KIND_DUMP;
		dump_rsp.status = STAT_DUMP;
		dump_rsp.last = 1'b1;
		if (cur[0].occ) begin
			dump_rsp.index = OUT_IDX_W'(dump_cnt_q);
			dump_rsp.valid = 1'b1;
			dump_rsp.id = cur[0].id;
			dump_rsp.c1 = OUT_CNT_W'(cur[0].c1);
			dump_rsp.c2 = OUT_CNT_W'(cur[0].c2);
			dump_rsp.last = !nb[0].occ;
		end
	end

	// Sequencer: idle, event lookup, dump streaming.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dump_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					dump_cnt_q <= '0;
					if (in_fire) begin
						if (req.req_type == REQ_DUMP) begin
							state_q <= ST_DUMP;
						end else if (req.req_type == REQ_T1 || req.req_type == REQ_T2) begin
							state_q <= ST_LOOK;
						end
					end
				end
				ST_LOOK: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DUMP: begin
					if (out_free) begin
						dump_cnt_q <= dump_cnt_q + IDX_W'(1);
						if (dump_rsp.last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Captured request.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_q <= req.sender_id;
			t1_q <= (req.req_type == REQ_T1);
		end
	end

	// Result register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= (state_q == ST_LOOK) || (state_q == ST_DUMP);
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_DUMP) begin
				rsp_q <= dump_rsp;
			end else begin
				rsp_q <= look_rsp;
			end
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.result_kind = rsp_q.kind;
	assign rsp.status = rsp_q.status;
	assign rsp.entry_index = rsp_q.index;
	assign rsp.entry_valid = rsp_q.valid;
	assign rsp.source_id = rsp_q.id;
	assign rsp.type1_count = rsp_q.c1;
	assign rsp.type2_count = rsp_q.c2;
	assign rsp.last = rsp_q.last;

	// Cells fill strictly in order from cell 0.
	`KECT_ASSERT_ALWAYS(a_fill_order, (occ_inc & occ_vec) == '0, "table cells not filled in order")
	// Stored ids are distinct, so a key hits at most one cell.
	`KECT_ASSERT_ALWAYS(a_single_hit, $onehot0(hit_vec), "key matched more than one cell")
	// A lookup with room at the output always yields a result beat.
	`KECT_ASSERT_NEXT(a_look_result, (state_q == ST_LOOK) && out_free, out_valid_q,
		"lookup finished without a result beat")
	// The final dump beat leaves the table empty.
	`KECT_ASSERT_NEXT(a_dump_clears, (state_q == ST_DUMP) && out_free && dump_rsp.last,
		occ_vec == '0, "table not empty after dump")
	// Requests are taken only while no event or dump is in progress.
	`KECT_ASSERT_SAME(a_accept_idle, in_fire, !ctl.upd_en && !ctl.shift_en,
		"request taken while the row is busy")

endmodule

@@ tb/sv/tb_keyed_event_counter_table_core.sv @@
// Self-checking testbench for the keyed event counter table core: directed table, random traffic.
module tb_keyed_event_counter_table_core;
	timeunit 1ns;
	timeprecision 1ps;
	import kect_pkg::*;

	// Request code that the block takes and drops.
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam logic [ID_W-1:0] ID_MAX = '1;
	localparam logic [ID_W-1:0] BURST_ID = 22'h1B5E3C;
	localparam int QUIET_LIMIT = 1000;
	localparam int RANDOM_ITEMS = 400;
	localparam int BURST_EVENTS = 16;
	localparam int TAIL_CYCLES = 20;
	localparam int POOL_MAX = 20;

	// One request, with an optional expectation typed in by hand.
	typedef struct {
		logic [REQ_W-1:0] kind;
		logic [ID_W-1:0]  id;
		bit               typed;
		bit               has_beat;
		kect_rsp_t        want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	kect_req_if req_ch();
	kect_rsp_if rsp_ch();

	keyed_event_counter_table_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	// Mirror of the table contents.
	logic [ID_W-1:0]  mirror_id [ENTRIES];
	logic [CNT_W-1:0] mirror_c1 [ENTRIES];
	logic [CNT_W-1:0] mirror_c2 [ENTRIES];
	int               mirror_fill;

	// Beats worked out for the latest request, and beats still owed by the block.
	kect_rsp_t req_beats[$];
	kect_rsp_t pending_beats[$];

	int errors = 0;
	int n_items = 0;
	int n_beats = 0;
	int n_rejects = 0;
	int n_dumps = 0;
	int quiet = 0;
	bit idle_on = 1'b1;

	always #2 clk = ~clk;

	task automatic report(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic kect_rsp_t beat(input logic kind, input logic [STAT_W-1:0] st,
		input int idx, input logic vld, input logic [ID_W-1:0] id,
		input logic [CNT_W-1:0] c1, input logic [CNT_W-1:0] c2, input logic lst);
		kect_rsp_t b;
		b.kind = kind;
		b.status = st;
		b.index = OUT_IDX_W'(idx);
		b.valid = vld;
		b.id = id;
		b.c1 = OUT_CNT_W'(c1);
		b.c2 = OUT_CNT_W'(c2);
		b.last = lst;
		return b;
	endfunction

	// Counter step that holds at the top value.
	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] c);
		return (c == {CNT_W{1'b1}}) ? c : c + 1'b1;
	endfunction

	// Apply one request to the mirror and list the beats it must produce.
	function automatic void tally_request(input logic [REQ_W-1:0] kind,
		input logic [ID_W-1:0] id);
		int slot;
		req_beats.delete();
		case (kind) inside
		REQ_DUMP: begin
			n_dumps++;
			if (mirror_fill == 0)
				req_beats.push_back(beat(KIND_DUMP, STAT_DUMP, 0, 1'b0, '0, '0, '0, 1'b1));
			for (int i = 0; i < mirror_fill; i++)
				req_beats.push_back(beat(KIND_DUMP, STAT_DUMP, i, 1'b1, mirror_id[i],
					mirror_c1[i], mirror_c2[i], i == mirror_fill - 1));
			for (int i = 0; i < ENTRIES; i++) begin
				mirror_c1[i] = '0;
				mirror_c2[i] = '0;
			end
			mirror_fill = 0;
		end
		REQ_T1, REQ_T2: begin
			slot = -1;
			for (int i = 0; i < mirror_fill; i++)
				if (slot < 0 && mirror_id[i] == id)
					slot = i;
			if (slot >= 0) begin
				// Known source: count it, even when the table is full.
				if (kind == REQ_T1)
					mirror_c1[slot] = bump(mirror_c1[slot]);
				else
					mirror_c2[slot] = bump(mirror_c2[slot]);
				req_beats.push_back(beat(KIND_ACK, STAT_OLD, slot, 1'b1, id,
					mirror_c1[slot], mirror_c2[slot], 1'b1));
			end else if (mirror_fill < ENTRIES) begin
				slot = mirror_fill;
				mirror_id[slot] = id;
				mirror_c1[slot] = CNT_W'(kind == REQ_T1);
				mirror_c2[slot] = CNT_W'(kind == REQ_T2);
				mirror_fill++;
				req_beats.push_back(beat(KIND_ACK, STAT_NEW, slot, 1'b1, id,
					mirror_c1[slot], mirror_c2[slot], 1'b1));
			end else begin
				n_rejects++;
				req_beats.push_back(beat(KIND_ACK, STAT_FULL, 0, 1'b0, '0, '0, '0, 1'b1));
			end
		end
		default: begin
		end
		endcase
	endfunction

	function automatic stim_row_t row(input logic [REQ_W-1:0] kind, input logic [ID_W-1:0] id);
		stim_row_t r;
		r.kind = kind;
		r.id = id;
		r.typed = 1'b0;
		r.has_beat = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic stim_row_t typed_row(input logic [REQ_W-1:0] kind,
		input logic [ID_W-1:0] id, input bit has_beat, input kect_rsp_t want);
		stim_row_t r;
		r = row(kind, id);
		r.typed = 1'b1;
		r.has_beat = has_beat;
		r.want = want;
		return r;
	endfunction

	function automatic logic [REQ_W-1:0] pick_event();
		return ($urandom_range(0, 1) != 0) ? REQ_T2 : REQ_T1;
	endfunction

	// Drive one request beat, with an occasional gap in front, and log what it owes.
	task automatic send(input stim_row_t r);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			req_ch.req_type <= REQ_W'($urandom_range(0, 3));
			req_ch.sender_id <= ID_W'($urandom);
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.req_type <= r.kind;
		req_ch.sender_id <= r.id;
		do @(posedge clk); while (!req_ch.ready);
		tally_request(r.kind, r.id);
		if (r.typed) begin
			if (r.has_beat)
				pending_beats.push_back(r.want);
		end else begin
			foreach (req_beats[i])
				pending_beats.push_back(req_beats[i]);
		end
		n_items++;
	endtask

	// Stop sending until every owed beat has come back.
	task automatic hold_until_drained();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending_beats.size() != 0)
			@(posedge clk);
	endtask

	task automatic compare_beat(input kect_rsp_t got, input kect_rsp_t want);
		if (got.kind !== want.kind)
			report($sformatf("result_kind %0d, expected %0d", got.kind, want.kind));
		if (got.status !== want.status)
			report($sformatf("status %0d, expected %0d", got.status, want.status));
		if (got.index !== want.index)
			report($sformatf("entry_index %0d, expected %0d", got.index, want.index));
		if (got.valid !== want.valid)
			report($sformatf("entry_valid %0d, expected %0d", got.valid, want.valid));
		if (got.id !== want.id)
			report($sformatf("source_id %h, expected %h", got.id, want.id));
		if (got.c1 !== want.c1)
			report($sformatf("type1_count %0d, expected %0d", got.c1, want.c1));
		if (got.c2 !== want.c2)
			report($sformatf("type2_count %0d, expected %0d", got.c2, want.c2));
		if (got.last !== want.last)
			report($sformatf("last %0d, expected %0d", got.last, want.last));
	endtask

	// Result side: random stall bursts while idling is on.
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(negedge clk);
			end
			rsp_ch.ready <= 1'b1;
		end
	end

	// Check every result beat against the oldest one owed.
	always @(posedge clk) begin
		kect_rsp_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.kind = rsp_ch.result_kind;
			got.status = rsp_ch.status;
			got.index = rsp_ch.entry_index;
			got.valid = rsp_ch.entry_valid;
			got.id = rsp_ch.source_id;
			got.c1 = rsp_ch.type1_count;
			got.c2 = rsp_ch.type2_count;
			got.last = rsp_ch.last;
			n_beats++;
			if (pending_beats.size() == 0)
				report($sformatf("result beat with nothing owed: kind %0d source_id %h",
					got.kind, got.id));
			else
				compare_beat(got, pending_beats.pop_front());
		end
	end

	// Watchdog on cycles with no beat on either channel.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("Watchdog: no beat for %0d cycles, %0d beats still owed",
						QUIET_LIMIT, pending_beats.size());
					$display("simulation failed");
					$finish;
				end
			end
		end
	end

	// Stimulus sequence.
	initial begin
		stim_row_t rows[$];
		logic [ID_W-1:0] pool [POOL_MAX];
		logic [ID_W-1:0] base;
		int pool_n;
		int ep_len;
		int pick;
		int n_random;
		bit paused;

		req_ch.valid = 1'b0;
		req_ch.req_type = REQ_T1;
		req_ch.sender_id = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			mirror_c1[i] = '0;
			mirror_c2[i] = '0;
		end
		mirror_fill = 0;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed table: empty dump, id extremes, both events, ignored type, fill to full,
		// rejection, known source on a full table, full dump, dump of a cleared table.
		rows.push_back(typed_row(REQ_DUMP, ID_MAX, 1'b1,
			beat(KIND_DUMP, STAT_DUMP, 0, 1'b0, '0, '0, '0, 1'b1)));
		rows.push_back(typed_row(REQ_T1, '0, 1'b1,
			beat(KIND_ACK, STAT_NEW, 0, 1'b1, '0, CNT_W'(1), CNT_W'(0), 1'b1)));
		rows.push_back(typed_row(REQ_T2, '0, 1'b1,
			beat(KIND_ACK, STAT_OLD, 0, 1'b1, '0, CNT_W'(1), CNT_W'(1), 1'b1)));
		rows.push_back(typed_row(REQ_T2, ID_MAX, 1'b1,
			beat(KIND_ACK, STAT_NEW, 1, 1'b1, ID_MAX, CNT_W'(0), CNT_W'(1), 1'b1)));
		rows.push_back(typed_row(REQ_UNUSED, 22'h000005, 1'b0, '0));
		rows.push_back(typed_row(REQ_T1, ID_MAX, 1'b1,
			beat(KIND_ACK, STAT_OLD, 1, 1'b1, ID_MAX, CNT_W'(1), CNT_W'(1), 1'b1)));
		for (int k = 2; k < ENTRIES; k++)
			rows.push_back(row((k % 2 != 0) ? REQ_T2 : REQ_T1, 22'h2AAAAA ^ ID_W'(k)));
		rows.push_back(typed_row(REQ_T1, 22'h155555, 1'b1,
			beat(KIND_ACK, STAT_FULL, 0, 1'b0, '0, '0, '0, 1'b1)));
		rows.push_back(typed_row(REQ_T2, '0, 1'b1,
			beat(KIND_ACK, STAT_OLD, 0, 1'b1, '0, CNT_W'(1), CNT_W'(2), 1'b1)));
		rows.push_back(row(REQ_DUMP, 22'h2AAAAA));
		rows.push_back(typed_row(REQ_DUMP, '0, 1'b1,
			beat(KIND_DUMP, STAT_DUMP, 0, 1'b0, '0, '0, '0, 1'b1)));
		foreach (rows[i])
			send(rows[i]);
		hold_until_drained();

		// Random episodes: a pool of related sources hit repeatedly, some noise, then a dump.
		n_random = 0;
		paused = 1'b0;
		while (n_random < RANDOM_ITEMS) begin
			idle_on = ($urandom_range(0, 3) != 0);
			pool_n = $urandom_range(1, POOL_MAX);
			base = ID_W'($urandom);
			for (int k = 0; k < pool_n; k++)
				pool[k] = ($urandom_range(0, 1) != 0) ?
					base ^ (ID_W'(1) << $urandom_range(0, ID_W - 1)) : ID_W'($urandom);
			ep_len = $urandom_range(4, 40);
			for (int j = 0; j < ep_len; j++) begin
				pick = $urandom_range(0, 99);
				if (pick < 4) begin
					send(row(REQ_UNUSED, ID_W'($urandom)));
				end else begin
					if (pick < 7)
						send(row(REQ_DUMP, ID_W'($urandom)));
					else if (pick < 14)
						send(row(pick_event(), ID_W'($urandom)));
					else
						send(row(pick_event(), pool[$urandom_range(0, pool_n - 1)]));
					n_random++;
				end
			end
			send(row(REQ_DUMP, ID_W'($urandom)));
			n_random++;
			if (!paused && n_random >= RANDOM_ITEMS / 2) begin
				hold_until_drained();
				paused = 1'b1;
			end
		end

		// Final stretch without idling: back-to-back events of both types on one source.
		idle_on = 1'b0;
		send(row(REQ_DUMP, ID_W'($urandom)));
		repeat (BURST_EVENTS) send(row(REQ_T1, BURST_ID));
		repeat (BURST_EVENTS) send(row(REQ_T2, BURST_ID));
		send(row(REQ_T1, ID_MAX));
		send(row(REQ_DUMP, '0));
		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d requests (%0d dumps, %0d rejected on a full table), %0d result beats;",
			n_items, n_dumps, n_rejects, n_beats);
		$display("fill, overflow, clearing, ignored requests and back-to-back counting were covered.");
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+rtl
rtl/kect_pkg.sv
rtl/kect_req_if.sv
rtl/kect_rsp_if.sv
rtl/kect_cell.sv
rtl/keyed_event_counter_table_core.sv
tb/sv/tb_keyed_event_counter_table_core.sv
